// ===== hw/rtl/xor_parity_frame_recovery_defines.svh =====
// assertion macros for the xor parity frame recovery block
`ifndef XOR_PARITY_FRAME_RECOVERY_DEFINES_SVH
`define XOR_PARITY_FRAME_RECOVERY_DEFINES_SVH

// same-cycle implication, checked on clk while out of reset
`define XPFR_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("xpfr same-cycle check failed");

// next-cycle implication, checked on clk while out of reset
`define XPFR_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("xpfr next-cycle check failed");

`endif

// ===== hw/rtl/xpfr_pkg.sv =====
// shared constants, types and helpers of the xor parity frame recovery block
`timescale 1ns / 1ps
package xpfr_pkg;

	localparam int FRAME_COUNT   = 1024;
	localparam int PAYLOAD_WORDS = 16;
	localparam int PARITY_SLOTS  = 32;
	localparam int FIFO_DEPTH    = 4;

	localparam int FRAME_AW = $clog2(FRAME_COUNT);
	localparam int WORD_AW  = 4;
	localparam int SLOT_AW  = (PARITY_SLOTS > 1) ? $clog2(PARITY_SLOTS) : 1;
	localparam int FILL_W   = $clog2(PARITY_SLOTS + 1);
	localparam int FADDR_W  = FRAME_AW + WORD_AW;
	localparam int PADDR_W  = SLOT_AW + WORD_AW;
	localparam int FIFO_AW  = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_REC_PARTNER,
		ACT_REC_BASE,
		ACT_STORE
	} act_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_DATA,
		OP_REC,
		OP_STORE
	} op_t;

	typedef enum logic [3:0] {
		F_CLEAR,
		F_IDLE,
		F_RDA,
		F_RDB,
		F_RDC,
		F_WAIT,
		F_W0,
		F_W1,
		F_W2,
		F_W3,
		F_PUSH,
		F_CMT,
		F_CMTL
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DATA,
		B_RD,
		B_WR,
		B_PRD,
		B_PWR,
		B_STORE
	} back_state_t;

	typedef struct packed {
		op_t                 op;
		logic                accept;
		logic [FRAME_AW-1:0] seq;
		logic [FRAME_AW-1:0] target;
		logic [FRAME_AW-1:0] known;
		logic [SLOT_AW-1:0]  pslot;
		logic [WORD_AW-1:0]  widx;
		logic [63:0]         word;
	} cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0]                      nrec;
		logic [PARITY_SLOTS-1:0][SLOT_AW-1:0]   slot;
		logic [PARITY_SLOTS-1:0][FRAME_AW-1:0]  tgt;
		logic [PARITY_SLOTS-1:0][FRAME_AW-1:0]  known;
	} rec_list_t;

	function automatic logic in_range(input logic [15:0] f);
		return {1'b0, f} < 17'(FRAME_COUNT);
	endfunction

endpackage

// ===== hw/rtl/xor_parity_frame_recovery.sv =====
// top level of the xor parity frame recovery receiver
`timescale 1ns / 1ps
// flow: a first word reads the delivery flags; on a data frame it waits for the back to drain
//   and walks the parity slots; a last word commits flags and slots, on a data frame also one flag
//   per frame rebuilt; the queue lets the front take later words while the back still emits results
// reset: the 1024 delivery flags are cleared in a sweep with busy high; results cannot stall
module xor_parity_frame_recovery (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [15:0] seq,
	input  logic [7:0]  stride,
	input  logic [3:0]  word_index,
	input  logic [63:0] payload_word,
	input  logic        last_word,
	output logic        strobe,
	output logic [9:0]  frame_seq,
	output logic [3:0]  out_word_index,
	output logic [63:0] out_word,
	output logic        rebuilt,
	output logic        run_end
);

	// front to queue
	xpfr_pkg::cmd_t      push_cmd, head_cmd;
	logic                push, fifo_full;
	// queue to back
	logic                pop, fifo_empty;
	// back status and the walk's rebuild list
	logic                back_idle;
	xpfr_pkg::rec_list_t recs;

	// the front plans each item: frame-new test, parity action, and on the first word of a
	// data frame the walk over the parity slots; it commits flags and slots on the last word
	xpfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (kind),
		.seq          (seq),
		.stride       (stride),
		.word_index   (word_index),
		.payload_word (payload_word),
		.last_word    (last_word),
		.busy         (busy),
		.push         (push),
		.cmd          (push_cmd),
		.fifo_full    (fifo_full),
		// a new walk rewrites the rebuild list, so it waits until the back has used it up
		.drain_idle   (back_idle && fifo_empty),
		.recs         (recs)
	);

	// word commands wait here so the front can plan ahead while the back emits results
	xpfr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.full   (fifo_full),
		.pop    (pop),
		.dout   (head_cmd),
		.empty  (fifo_empty)
	);

	// the back keeps frame and parity words, rebuilds by xor and drives the result strobe
	xpfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (fifo_empty),
		.pop            (pop),
		.head           (head_cmd),
		.recs           (recs),
		.idle           (back_idle),
		.strobe         (strobe),
		.frame_seq      (frame_seq),
		.out_word_index (out_word_index),
		.out_word       (out_word),
		.rebuilt        (rebuilt),
		.run_end        (run_end)
	);

endmodule

// ===== hw/rtl/xpfr_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module xpfr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/xpfr_fifo.sv =====
// short command queue between the front and back parts
`timescale 1ns / 1ps
module xpfr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xpfr_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output xpfr_pkg::cmd_t dout,
	output logic           empty
);

	xpfr_pkg::cmd_t mem [xpfr_pkg::FIFO_DEPTH];
	logic [xpfr_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [xpfr_pkg::FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (xpfr_pkg::FIFO_AW + 1)'(xpfr_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/xpfr_front.sv =====
// front part: packet planning, parity walk, flag and slot table commit
`timescale 1ns / 1ps
module xpfr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  kind,
	input  logic [15:0]           seq,
	input  logic [7:0]            stride,
	input  logic [3:0]            word_index,
	input  logic [63:0]           payload_word,
	input  logic                  last_word,
	output logic                  busy,
	output logic                  push,
	output xpfr_pkg::cmd_t        cmd,
	input  logic                  fifo_full,
	input  logic                  drain_idle,
	output xpfr_pkg::rec_list_t   recs
);

	localparam int PS = xpfr_pkg::PARITY_SLOTS;
	localparam int FA = xpfr_pkg::FRAME_AW;
	localparam int SA = xpfr_pkg::SLOT_AW;
	localparam int FW = xpfr_pkg::FILL_W;

	xpfr_pkg::front_state_t state_q, state_d;

	// current item
	logic        it_kind_q, it_last_q;
	logic [15:0] it_seq_q;
	logic [7:0]  it_stride_q;
	logic [3:0]  it_w_q;
	logic [63:0] it_word_q;
	logic [15:0] it_part;

	// open packet plan
	logic              open_q;
	logic              pkind_q, paccept_q;
	logic [15:0]       pseq_q;
	logic [7:0]        pstride_q;
	xpfr_pkg::act_t    pact_q, dec_act;
	logic [15:0]       pl_part;
	logic [FA-1:0]     pl_target, pl_known;

	// slot table
	logic [SA-1:0] map_q  [PS];
	logic [SA-1:0] wmap_q [PS];
	logic [23:0]   meta_q [PS];
	logic [FW-1:0] fill_q, wn_q, wi_q, nrec_q, ck_q, wlast;

	// walk step
	logic [SA-1:0] pw, p_q;
	logic [15:0]   base_q, part_q;
	logic          hbf_q, flagb_q, hitb_q, hitp_q, hit;
	logic [FA-1:0] cmp_val;
	logic          wk_hb, wk_hp, wk_c1, wk_c2, wk_drop;

	logic [SA-1:0] rec_slot_q  [PS];
	logic [FA-1:0] rec_tgt_q   [PS];
	logic [FA-1:0] rec_known_q [PS];

	logic [FA-1:0] clr_q;

	// flag memory
	logic          flag_we;
	logic [FA-1:0] flag_waddr, flag_raddr;
	logic [0:0]    flag_wdata, flag_rdata;

	xpfr_ram #(.WIDTH(1), .DEPTH(xpfr_pkg::FRAME_COUNT)) u_flags (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.raddr (flag_raddr),
		.rdata (flag_rdata)
	);

	assign busy    = (state_q != xpfr_pkg::F_IDLE);
	assign it_part = it_seq_q + {8'b0, it_stride_q};
	assign pl_part = pseq_q + {8'b0, pstride_q};
	assign pl_target = (pact_q == xpfr_pkg::ACT_REC_PARTNER) ? pl_part[FA-1:0] : pseq_q[FA-1:0];
	assign pl_known  = (pact_q == xpfr_pkg::ACT_REC_PARTNER) ? pseq_q[FA-1:0] : pl_part[FA-1:0];
	assign pw    = wmap_q[wi_q[SA-1:0]];
	assign wlast = wn_q - FW'(1);

	always_comb begin
		recs.nrec = nrec_q;
		for (int i = 0; i < PS; i++) begin
			recs.slot[i]  = rec_slot_q[i];
			recs.tgt[i]   = rec_tgt_q[i];
			recs.known[i] = rec_known_q[i];
		end
	end

	// match against frames already being rebuilt by this walk
	always_comb begin
		cmp_val = (state_q == xpfr_pkg::F_W1) ? base_q[FA-1:0] : part_q[FA-1:0];
		hit = 1'b0;
		for (int i = 0; i < PS; i++) begin
			if ((FW'(i) < nrec_q) && (rec_tgt_q[i] == cmp_val)) begin
				hit = 1'b1;
			end
		end
	end

	always_comb begin
		wk_hb = xpfr_pkg::in_range(base_q) &&
			(flagb_q || ((base_q == pseq_q) && paccept_q) || hitb_q);
		wk_hp = xpfr_pkg::in_range(part_q) &&
			(flag_rdata[0] || ((part_q == pseq_q) && paccept_q) || hitp_q);
		wk_c1 = (pseq_q == base_q) && wk_hb && !wk_hp && xpfr_pkg::in_range(part_q);
		wk_c2 = !wk_c1 && (pseq_q == part_q) && wk_hp && !wk_hb &&
			xpfr_pkg::in_range(base_q);
		wk_drop = wk_c1 || wk_c2 || (wk_hb && wk_hp);
	end

	// parity action from the two flags
	always_comb begin
		dec_act = xpfr_pkg::ACT_NONE;
		if (xpfr_pkg::in_range(it_seq_q) && xpfr_pkg::in_range(it_part)) begin
			if (hbf_q && !flag_rdata[0]) begin
				dec_act = xpfr_pkg::ACT_REC_PARTNER;
			end else if (!hbf_q && flag_rdata[0]) begin
				dec_act = xpfr_pkg::ACT_REC_BASE;
			end else if (!hbf_q && !flag_rdata[0] && (fill_q < FW'(PS))) begin
				dec_act = xpfr_pkg::ACT_STORE;
			end
		end
	end

	// command for the back part
	always_comb begin
		cmd.op = xpfr_pkg::OP_NONE;
		if ({1'b0, it_w_q} < 5'(xpfr_pkg::PAYLOAD_WORDS)) begin
			if (!pkind_q) begin
				cmd.op = xpfr_pkg::OP_DATA;
			end else begin
				case (pact_q)
					xpfr_pkg::ACT_REC_PARTNER: cmd.op = xpfr_pkg::OP_REC;
					xpfr_pkg::ACT_REC_BASE:    cmd.op = xpfr_pkg::OP_REC;
					xpfr_pkg::ACT_STORE:       cmd.op = xpfr_pkg::OP_STORE;
					default:                   cmd.op = xpfr_pkg::OP_NONE;
				endcase
			end
		end
		cmd.accept = paccept_q;
		cmd.seq    = pseq_q[FA-1:0];
		cmd.target = pl_target;
		cmd.known  = pl_known;
		cmd.pslot  = map_q[fill_q[SA-1:0]];
		cmd.widx   = it_w_q;
		cmd.word   = it_word_q;
	end

	always_comb begin
		state_d    = state_q;
		flag_raddr = it_seq_q[FA-1:0];
		flag_we    = 1'b0;
		flag_waddr = clr_q;
		flag_wdata = 1'b0;
		push       = 1'b0;
		case (state_q)
			xpfr_pkg::F_CLEAR: begin
				flag_we = 1'b1;
				if (clr_q == FA'(xpfr_pkg::FRAME_COUNT - 1)) begin
					state_d = xpfr_pkg::F_IDLE;
				end
			end
			xpfr_pkg::F_IDLE: begin
				if (start) begin
					state_d = open_q ? xpfr_pkg::F_PUSH : xpfr_pkg::F_RDA;
				end
			end
			xpfr_pkg::F_RDA: begin
				state_d = xpfr_pkg::F_RDB;
			end
			xpfr_pkg::F_RDB: begin
				flag_raddr = it_part[FA-1:0];
				state_d = it_kind_q ? xpfr_pkg::F_RDC : xpfr_pkg::F_WAIT;
			end
			xpfr_pkg::F_RDC: begin
				state_d = xpfr_pkg::F_PUSH;
			end
			xpfr_pkg::F_WAIT: begin
				if (drain_idle) begin
					state_d = xpfr_pkg::F_W0;
				end
			end
			xpfr_pkg::F_W0: begin
				state_d = (wi_q < wn_q) ? xpfr_pkg::F_W1 : xpfr_pkg::F_PUSH;
			end
			xpfr_pkg::F_W1: begin
				flag_raddr = base_q[FA-1:0];
				state_d = xpfr_pkg::F_W2;
			end
			xpfr_pkg::F_W2: begin
				flag_raddr = part_q[FA-1:0];
				state_d = xpfr_pkg::F_W3;
			end
			xpfr_pkg::F_W3: begin
				state_d = xpfr_pkg::F_W0;
			end
			xpfr_pkg::F_PUSH: begin
				if ((cmd.op == xpfr_pkg::OP_NONE) || !fifo_full) begin
					push = (cmd.op != xpfr_pkg::OP_NONE);
					state_d = it_last_q ? xpfr_pkg::F_CMT : xpfr_pkg::F_IDLE;
				end
			end
			xpfr_pkg::F_CMT: begin
				flag_wdata = 1'b1;
				if (!pkind_q) begin
					flag_we    = paccept_q;
					flag_waddr = pseq_q[FA-1:0];
					state_d    = xpfr_pkg::F_CMTL;
				end else begin
					flag_we    = (pact_q == xpfr_pkg::ACT_REC_PARTNER) ||
						(pact_q == xpfr_pkg::ACT_REC_BASE);
					flag_waddr = pl_target;
					state_d    = xpfr_pkg::F_IDLE;
				end
			end
			xpfr_pkg::F_CMTL: begin
				flag_wdata = 1'b1;
				flag_waddr = rec_tgt_q[ck_q[SA-1:0]];
				if (ck_q < nrec_q) begin
					flag_we = 1'b1;
				end else begin
					state_d = xpfr_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = xpfr_pkg::F_IDLE;
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			xpfr_pkg::F_IDLE: begin
				if (start) begin
					it_kind_q   <= kind;
					it_seq_q    <= seq;
					it_stride_q <= stride;
					it_w_q      <= word_index;
					it_word_q   <= payload_word;
					it_last_q   <= last_word;
				end
			end
			xpfr_pkg::F_RDB: begin
				hbf_q <= flag_rdata[0];
				if (!it_kind_q) begin
					pkind_q   <= 1'b0;
					pseq_q    <= it_seq_q;
					pstride_q <= it_stride_q;
					paccept_q <= xpfr_pkg::in_range(it_seq_q) && !flag_rdata[0];
					pact_q    <= xpfr_pkg::ACT_NONE;
				end
			end
			xpfr_pkg::F_RDC: begin
				pkind_q   <= 1'b1;
				pseq_q    <= it_seq_q;
				pstride_q <= it_stride_q;
				paccept_q <= 1'b0;
				pact_q    <= dec_act;
			end
			xpfr_pkg::F_W0: begin
				p_q    <= pw;
				base_q <= meta_q[pw][15:0];
				part_q <= meta_q[pw][15:0] + {8'b0, meta_q[pw][23:16]};
			end
			xpfr_pkg::F_W1: begin
				hitb_q <= hit;
			end
			xpfr_pkg::F_W2: begin
				flagb_q <= flag_rdata[0];
				hitp_q  <= hit;
			end
			xpfr_pkg::F_W3: begin
				if (wk_c1 || wk_c2) begin
					rec_slot_q[nrec_q[SA-1:0]]  <= p_q;
					rec_tgt_q[nrec_q[SA-1:0]]   <= wk_c1 ? part_q[FA-1:0] : base_q[FA-1:0];
					rec_known_q[nrec_q[SA-1:0]] <= wk_c1 ? base_q[FA-1:0] : part_q[FA-1:0];
				end
			end
			xpfr_pkg::F_CMT: begin
				if (pkind_q && (pact_q == xpfr_pkg::ACT_STORE)) begin
					meta_q[map_q[fill_q[SA-1:0]]] <= {pstride_q, pseq_q};
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xpfr_pkg::F_CLEAR;
			clr_q   <= '0;
			open_q  <= 1'b0;
			fill_q  <= '0;
			wn_q    <= '0;
			wi_q    <= '0;
			nrec_q  <= '0;
			ck_q    <= '0;
			for (int i = 0; i < PS; i++) begin
				map_q[i]  <= SA'(i);
				wmap_q[i] <= SA'(i);
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				xpfr_pkg::F_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				xpfr_pkg::F_RDB: begin
					if (!it_kind_q) begin
						open_q <= 1'b1;
					end
				end
				xpfr_pkg::F_RDC: begin
					open_q <= 1'b1;
				end
				xpfr_pkg::F_WAIT: begin
					if (drain_idle) begin
						wmap_q <= map_q;
						wn_q   <= fill_q;
						wi_q   <= '0;
						nrec_q <= '0;
					end
				end
				xpfr_pkg::F_W3: begin
					if (wk_drop) begin
						wmap_q[wi_q[SA-1:0]]  <= wmap_q[wlast[SA-1:0]];
						wmap_q[wlast[SA-1:0]] <= wmap_q[wi_q[SA-1:0]];
						wn_q <= wlast;
					end else begin
						wi_q <= wi_q + 1'b1;
					end
					if (wk_c1 || wk_c2) begin
						nrec_q <= nrec_q + 1'b1;
					end
				end
				xpfr_pkg::F_CMT: begin
					ck_q <= '0;
					if (pkind_q) begin
						open_q <= 1'b0;
						if (pact_q == xpfr_pkg::ACT_STORE) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				xpfr_pkg::F_CMTL: begin
					if (ck_q < nrec_q) begin
						ck_q <= ck_q + 1'b1;
					end else begin
						map_q  <= wmap_q;
						fill_q <= wn_q;
						open_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/xpfr_back.sv =====
// back part: frame and parity word storage, xor rebuild and result output
`timescale 1ns / 1ps
module xpfr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	output logic                        pop,
	input  xpfr_pkg::cmd_t              head,
	input  xpfr_pkg::rec_list_t         recs,
	output logic                        idle,
	output logic                        strobe,
	output logic [xpfr_pkg::FRAME_AW-1:0] frame_seq,
	output logic [3:0]                  out_word_index,
	output logic [63:0]                 out_word,
	output logic                        rebuilt,
	output logic                        run_end
);

	localparam int SA = xpfr_pkg::SLOT_AW;
	localparam int FW = xpfr_pkg::FILL_W;

	xpfr_pkg::back_state_t state_q, state_d;
	xpfr_pkg::cmd_t        cmd_q;
	logic [FW-1:0]         k_q;
	logic [SA-1:0]         ki;
	logic                  last_k;

	logic                         fr_we, pr_we;
	logic [xpfr_pkg::FADDR_W-1:0] fr_waddr, fr_raddr;
	logic [xpfr_pkg::PADDR_W-1:0] pr_waddr, pr_raddr;
	logic [63:0]                  fr_wdata, fr_rdata, pr_rdata;

	logic                         emit, e_reb, e_end;
	logic [xpfr_pkg::FRAME_AW-1:0] e_seq;
	logic [63:0]                  e_word;

	xpfr_ram #(.WIDTH(64), .DEPTH(xpfr_pkg::FRAME_COUNT * xpfr_pkg::PAYLOAD_WORDS)) u_frames (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	xpfr_ram #(.WIDTH(64), .DEPTH(xpfr_pkg::PARITY_SLOTS * xpfr_pkg::PAYLOAD_WORDS)) u_parity (
		.clk   (clk),
		.we    (pr_we),
		.waddr (pr_waddr),
		.wdata (cmd_q.word),
		.raddr (pr_raddr),
		.rdata (pr_rdata)
	);

	assign idle   = (state_q == xpfr_pkg::B_IDLE);
	assign ki     = k_q[SA-1:0];
	assign last_k = ((k_q + FW'(1)) == recs.nrec);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		fr_we    = 1'b0;
		fr_waddr = {cmd_q.seq, cmd_q.widx};
		fr_wdata = cmd_q.word;
		fr_raddr = {recs.known[ki], cmd_q.widx};
		pr_raddr = {recs.slot[ki], cmd_q.widx};
		pr_we    = 1'b0;
		pr_waddr = {cmd_q.pslot, cmd_q.widx};
		emit     = 1'b0;
		e_seq    = cmd_q.seq;
		e_word   = cmd_q.word;
		e_reb    = 1'b0;
		e_end    = 1'b0;
		case (state_q)
			xpfr_pkg::B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (head.op)
						xpfr_pkg::OP_DATA: begin
							if (head.accept) begin
								state_d = xpfr_pkg::B_DATA;
							end else if (recs.nrec != '0) begin
								state_d = xpfr_pkg::B_RD;
							end
						end
						xpfr_pkg::OP_REC:   state_d = xpfr_pkg::B_PRD;
						xpfr_pkg::OP_STORE: state_d = xpfr_pkg::B_STORE;
						default:            state_d = xpfr_pkg::B_IDLE;
					endcase
				end
			end
			xpfr_pkg::B_DATA: begin
				fr_we = 1'b1;
				emit  = 1'b1;
				e_end = (recs.nrec == '0);
				state_d = e_end ? xpfr_pkg::B_IDLE : xpfr_pkg::B_RD;
			end
			xpfr_pkg::B_RD: begin
				state_d = xpfr_pkg::B_WR;
			end
			xpfr_pkg::B_WR: begin
				fr_we    = 1'b1;
				fr_waddr = {recs.tgt[ki], cmd_q.widx};
				fr_wdata = pr_rdata ^ fr_rdata;
				emit     = 1'b1;
				e_seq    = recs.tgt[ki];
				e_word   = pr_rdata ^ fr_rdata;
				e_reb    = 1'b1;
				e_end    = last_k;
				state_d  = last_k ? xpfr_pkg::B_IDLE : xpfr_pkg::B_RD;
			end
			xpfr_pkg::B_PRD: begin
				fr_raddr = {cmd_q.known, cmd_q.widx};
				state_d  = xpfr_pkg::B_PWR;
			end
			xpfr_pkg::B_PWR: begin
				fr_we    = 1'b1;
				fr_waddr = {cmd_q.target, cmd_q.widx};
				fr_wdata = cmd_q.word ^ fr_rdata;
				emit     = 1'b1;
				e_seq    = cmd_q.target;
				e_word   = cmd_q.word ^ fr_rdata;
				e_reb    = 1'b1;
				e_end    = 1'b1;
				state_d  = xpfr_pkg::B_IDLE;
			end
			xpfr_pkg::B_STORE: begin
				pr_we   = 1'b1;
				state_d = xpfr_pkg::B_IDLE;
			end
			default: begin
				state_d = xpfr_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (emit) begin
			frame_seq      <= e_seq;
			out_word_index <= cmd_q.widx;
			out_word       <= e_word;
			rebuilt        <= e_reb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xpfr_pkg::B_IDLE;
			k_q     <= '0;
			strobe  <= 1'b0;
			run_end <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= emit;
			run_end <= emit && e_end;
			if (state_q == xpfr_pkg::B_IDLE) begin
				k_q <= '0;
			end else if (state_q == xpfr_pkg::B_WR) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/xpfr_checker.sv =====
// port-level checks for the xor parity frame recovery block
`timescale 1ns / 1ps
`include "xor_parity_frame_recovery_defines.svh"
module xpfr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic run_end
);

	`XPFR_AST_IMP(a_run_end_with_strobe, !strobe, !run_end)
	`XPFR_AST_NXT(a_busy_after_accept, start && !busy, busy)
	`XPFR_AST_NXT(a_strobe_gap, strobe, !strobe)

endmodule

bind xor_parity_frame_recovery xpfr_checker u_chk (.*);

// ===== dv/xor_parity_frame_recovery_tb.sv =====
// self-checking testbench for the xor parity frame recovery receiver
`timescale 1ns / 1ps
module xor_parity_frame_recovery_tb;
	import xpfr_pkg::*;

	// a data frame that is new reuses the partner-rebuild action code
	localparam act_t ACT_ACCEPT = ACT_REC_PARTNER;

	typedef struct {
		bit        kind;
		bit [15:0] seq;
		bit [7:0]  stride;
		bit [3:0]  widx;
		bit [63:0] word;
		bit        last;
		bit        hold;   // wait for every owed result before sending this item
		int        nres;   // results this item causes
	} pkt_item_t;

	typedef struct {
		bit [9:0]  fseq;
		bit [3:0]  widx;
		bit [63:0] word;
		bit        reb;
		bit        rend;
	} word_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        kind = 1'b0;
	logic [15:0] seq = '0;
	logic [7:0]  stride = '0;
	logic [3:0]  word_index = '0;
	logic [63:0] payload_word = '0;
	logic        last_word = 1'b0;
	logic        strobe;
	logic [9:0]  frame_seq;
	logic [3:0]  out_word_index;
	logic [63:0] out_word;
	logic        rebuilt;
	logic        run_end;

	xor_parity_frame_recovery DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .seq(seq), .stride(stride), .word_index(word_index),
		.payload_word(payload_word), .last_word(last_word),
		.strobe(strobe), .frame_seq(frame_seq), .out_word_index(out_word_index),
		.out_word(out_word), .rebuilt(rebuilt), .run_end(run_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// shadow state of the receiver
	// ---------------------------------------------------------------
	bit        dlv [FRAME_COUNT];                  // frame delivered flags
	bit [63:0] fwords [FRAME_COUNT*PAYLOAD_WORDS]; // stored frame payload
	bit [23:0] pmeta [PARITY_SLOTS];               // {stride, base} per parity slot
	bit [63:0] pwords [PARITY_SLOTS*PAYLOAD_WORDS];
	int        pfill;
	bit        open_pkt;                           // a packet is in progress
	bit        open_kind;
	bit [15:0] open_seq;
	bit [7:0]  open_stride;
	act_t      open_act;

	// recovery walk scratch
	int wk_perm [PARITY_SLOTS];
	int wk_slot [PARITY_SLOTS];
	int wk_tgt [PARITY_SLOTS];
	int wk_known [PARITY_SLOTS];
	int wk_n, wk_nrec;

	pkt_item_t items [$];        // items waiting for the driver
	word_out_t owed_words [$];   // expected results, oldest first

	int owed = 0;     // results owed by accepted items
	int got = 0;      // results seen
	int errs = 0;

	// action a packet takes, judged on its first word
	function automatic act_t plan_action(bit k, bit [15:0] s, bit [7:0] st);
		bit [15:0] pt;
		pt = s + st;
		if (!k)
			return (s < FRAME_COUNT && !dlv[s]) ? ACT_ACCEPT : ACT_NONE;
		if (s >= FRAME_COUNT || pt >= FRAME_COUNT) return ACT_NONE;
		if (dlv[s] && !dlv[pt]) return ACT_REC_PARTNER;
		if (!dlv[s] && dlv[pt]) return ACT_REC_BASE;
		if (!dlv[s] && !dlv[pt] && pfill < PARITY_SLOTS) return ACT_STORE;
		return ACT_NONE;
	endfunction

	// frame counts as present once delivered, accepted now, or rebuilt earlier in the walk
	function automatic bit frame_known(int f, int s, bit acc);
		if (f >= FRAME_COUNT) return 1'b0;
		if (dlv[f] || (f == s && acc)) return 1'b1;
		for (int k = 0; k < wk_nrec; k++)
			if (wk_tgt[k] == f) return 1'b1;
		return 1'b0;
	endfunction

	// walk stored parities in order, swap-removing the ones that recover or are complete
	function automatic void parity_walk(int s, bit acc);
		int i, p, b, pt;
		bit hb, hp, drop;
		i = 0;
		wk_n = pfill;
		wk_nrec = 0;
		for (int k = 0; k < wk_n; k++) wk_perm[k] = k;
		while (i < wk_n) begin
			p = wk_perm[i];
			b = pmeta[p][15:0];
			pt = (b + pmeta[p][23:16]) & 16'hffff;
			hb = frame_known(b, s, acc);
			hp = frame_known(pt, s, acc);
			drop = 1'b0;
			if (s == b && hb && !hp && pt < FRAME_COUNT) begin
				wk_slot[wk_nrec] = p; wk_tgt[wk_nrec] = pt; wk_known[wk_nrec] = b;
				wk_nrec++; drop = 1'b1;
			end else if (s == pt && hp && !hb && b < FRAME_COUNT) begin
				wk_slot[wk_nrec] = p; wk_tgt[wk_nrec] = b; wk_known[wk_nrec] = pt;
				wk_nrec++; drop = 1'b1;
			end else if (hb && hp) begin
				drop = 1'b1;
			end
			if (drop) begin
				wk_n--;
				wk_perm[i] = wk_perm[wk_n];
			end else begin
				i++;
			end
		end
	endfunction

	// advance the shadow by one item, queue its results and return how many
	function automatic int recover_words(pkt_item_t it);
		word_out_t res [$];
		word_out_t r;
		bit [15:0] pt;
		int tgt, known, w;
		bit [63:0] v;
		bit [23:0] tm [PARITY_SLOTS];
		bit [63:0] tw [PARITY_SLOTS*PAYLOAD_WORDS];
		if (!open_pkt) begin
			open_act = plan_action(it.kind, it.seq, it.stride);
			open_kind = it.kind;
			open_seq = it.seq;
			open_stride = it.stride;
			open_pkt = 1'b1;
		end
		pt = open_seq + open_stride;
		tgt = (open_act == ACT_REC_PARTNER) ? pt : open_seq;
		known = (open_act == ACT_REC_PARTNER) ? open_seq : pt;
		w = it.widx;
		if (!open_kind) begin
			if (open_act == ACT_ACCEPT) begin
				fwords[open_seq*PAYLOAD_WORDS + w] = it.word;
				r = '{open_seq[9:0], it.widx, it.word, 1'b0, 1'b0};
				res.push_back(r);
			end
			parity_walk(open_seq, open_act == ACT_ACCEPT);
			for (int k = 0; k < wk_nrec; k++) begin
				v = pwords[wk_slot[k]*PAYLOAD_WORDS + w] ^
					fwords[wk_known[k]*PAYLOAD_WORDS + w];
				fwords[wk_tgt[k]*PAYLOAD_WORDS + w] = v;
				r = '{wk_tgt[k][9:0], it.widx, v, 1'b1, 1'b0};
				res.push_back(r);
			end
		end else if (open_act == ACT_REC_PARTNER || open_act == ACT_REC_BASE) begin
			v = it.word ^ fwords[known*PAYLOAD_WORDS + w];
			fwords[tgt*PAYLOAD_WORDS + w] = v;
			r = '{tgt[9:0], it.widx, v, 1'b1, 1'b0};
			res.push_back(r);
		end else if (open_act == ACT_STORE) begin
			pwords[pfill*PAYLOAD_WORDS + w] = it.word;
		end

		if (it.last) begin
			if (!open_kind) begin
				if (open_act == ACT_ACCEPT) dlv[open_seq] = 1'b1;
				parity_walk(open_seq, open_act == ACT_ACCEPT);
				for (int k = 0; k < wk_nrec; k++) dlv[wk_tgt[k]] = 1'b1;
				// compact the surviving slots in walk order
				for (int k = 0; k < wk_n; k++) begin
					tm[k] = pmeta[wk_perm[k]];
					for (int j = 0; j < PAYLOAD_WORDS; j++)
						tw[k*PAYLOAD_WORDS + j] = pwords[wk_perm[k]*PAYLOAD_WORDS + j];
				end
				for (int k = 0; k < wk_n; k++) begin
					pmeta[k] = tm[k];
					for (int j = 0; j < PAYLOAD_WORDS; j++)
						pwords[k*PAYLOAD_WORDS + j] = tw[k*PAYLOAD_WORDS + j];
				end
				pfill = wk_n;
			end else if (open_act == ACT_REC_PARTNER || open_act == ACT_REC_BASE) begin
				dlv[tgt] = 1'b1;
			end else if (open_act == ACT_STORE) begin
				pmeta[pfill] = {open_stride, open_seq};
				pfill++;
			end
			open_pkt = 1'b0;
		end

		if (res.size() != 0) res[res.size()-1].rend = 1'b1;
		foreach (res[k]) owed_words.push_back(res[k]);
		return res.size();
	endfunction

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	// every full packet carries words 0, 5, 10 and 15 in a random order, so each
	// word position a later rebuild can read has been written; together they toggle
	// every bit of the word index
	task automatic send_packet(bit k, bit [15:0] s, bit [7:0] st, int nw, bit hold,
			bit ext);
		bit [3:0] pos [4];
		bit [3:0] t;
		int j2;
		pkt_item_t it;
		pos = '{4'd0, 4'd5, 4'd10, 4'd15};
		for (int j = 3; j > 0; j--) begin
			j2 = $urandom_range(0, j);
			t = pos[j]; pos[j] = pos[j2]; pos[j2] = t;
		end
		for (int j = 0; j < nw; j++) begin
			it.kind = k;
			it.seq = s;
			it.stride = st;
			// header fields of later words are ignored, so scramble them
			if (j != 0) begin
				it.kind = 1'($urandom_range(0, 1));
				it.seq = 16'($urandom);
				it.stride = 8'($urandom);
			end
			it.widx = pos[j];
			it.word = ext ? ((j % 2) ? '1 : '0) : {$urandom, $urandom};
			it.last = (j == nw - 1);
			it.hold = hold && (j == 0);
			it.nres = recover_words(it);
			items.push_back(it);
		end
	endtask

	// short packets only where nothing they leave unwritten is ever read
	task automatic send_any(bit k, bit [15:0] s, bit [7:0] st);
		bit short_ok;
		short_ok = (k && plan_action(k, s, st) == ACT_NONE) || (!k && s >= FRAME_COUNT);
		send_packet(k, s, st, (short_ok && $urandom_range(0, 1)) ?
			$urandom_range(1, 4) : 4, 1'b0, 1'b0);
	endtask

	initial begin
		int order [64];
		int j2, t;
		bit k;
		// directed part
		send_packet(1'b0, 16'd0, 8'd0, 4, 1'b0, 1'b1);      // new frame, payload extremes
		send_packet(1'b1, 16'd0, 8'd1, 4, 1'b0, 1'b0);      // rebuild partner
		send_packet(1'b0, 16'd262, 8'd0, 4, 1'b0, 1'b0);
		send_packet(1'b1, 16'd7, 8'd255, 4, 1'b0, 1'b1);    // rebuild base
		send_packet(1'b1, 16'd5, 8'd251, 4, 1'b0, 1'b0);    // both missing: stored
		send_packet(1'b1, 16'd1023, 8'd0, 4, 1'b0, 1'b0);   // pair onto itself: stored
		send_packet(1'b0, 16'd256, 8'd0, 4, 1'b0, 1'b0);    // walk rebuilds frame 5
		send_packet(1'b0, 16'd1023, 8'd0, 4, 1'b0, 1'b0);   // walk purges the pair
		send_any(1'b1, 16'd0, 8'd1);                         // both present: dropped
		send_any(1'b1, 16'd65535, 8'd255);                   // out of range: dropped
		send_packet(1'b0, 16'd0, 8'd0, 4, 1'b0, 1'b0);      // duplicate frame
		send_packet(1'b0, 16'd40000, 8'd0, 2, 1'b0, 1'b0);  // out-of-range frame

		// fill the parity table, one more than fits, after a full drain
		for (int i = 0; i <= PARITY_SLOTS; i++)
			send_packet(1'b1, 16'(300 + 2*i), 8'd1, 4, i == 0, 1'b0);
		// frames of those pairs in random order: long walks with many rebuilds
		for (int i = 0; i < 64; i++) order[i] = i;
		for (int i = 63; i > 0; i--) begin
			j2 = $urandom_range(0, i);
			t = order[i]; order[i] = order[j2]; order[j2] = t;
		end
		for (int i = 0; i < 12; i++)
			send_packet(1'b0, 16'(300 + order[i]), 8'd0, 4, 1'b0, 1'b0);

		// random part: mostly frames and parities over a small pool
		while (items.size() < 240) begin
			t = $urandom_range(0, 99);
			k = $urandom_range(0, 1);
			if (t < 85)
				send_any(k, 16'(400 + $urandom_range(0, 50)),
					k ? 8'($urandom_range(1, 6)) : 8'($urandom));
			else if (t < 92)
				send_any(k, 16'(300 + $urandom_range(0, 63)), 8'($urandom_range(0, 3)));
			else
				send_any(k, 16'($urandom), 8'($urandom));
		end
	end

	// ---------------------------------------------------------------
	// driver
	// ---------------------------------------------------------------
	int gap = 0;
	int cur_nres = 0;
	int sent = 0;

	always @(posedge clk or negedge arst_n) begin
		int owed_now;
		pkt_item_t it;
		if (!arst_n) begin
			start <= 1'b0;
			gap <= 0;
		end else begin
			owed_now = owed + ((start && !busy) ? cur_nres : 0);
			owed <= owed_now;
			if (start && busy) begin
				// item still waiting for the block
			end else if (gap != 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (items.size() != 0 && !(items[0].hold && owed_now != got)) begin
				it = items.pop_front();
				kind <= it.kind;
				seq <= it.seq;
				stride <= it.stride;
				word_index <= it.widx;
				payload_word <= it.word;
				last_word <= it.last;
				cur_nres <= it.nres;
				start <= 1'b1;
				sent <= sent + 1;
				// stretches with no gaps, otherwise a gap from $urandom_range after each item
				gap <= (sent % 60 < 15) ? 0 : $urandom_range(0, 10);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		word_out_t e;
		if (arst_n && strobe) begin
			got <= got + 1;
			if (owed_words.size() == 0) begin
				$error("unexpected result frame_seq=%0d word=%h", frame_seq, out_word);
				errs++;
			end else begin
				e = owed_words.pop_front();
				if (frame_seq !== e.fseq) begin
					$error("frame_seq: expected %0d, got %0d", e.fseq, frame_seq);
					errs++;
				end
				if (out_word_index !== e.widx) begin
					$error("out_word_index: expected %0d, got %0d", e.widx, out_word_index);
					errs++;
				end
				if (out_word !== e.word) begin
					$error("out_word: expected %h, got %h", e.word, out_word);
					errs++;
				end
				if (rebuilt !== e.reb) begin
					$error("rebuilt: expected %0d, got %0d", e.reb, rebuilt);
					errs++;
				end
				if (run_end !== e.rend) begin
					$error("run_end: expected %0d, got %0d", e.rend, run_end);
					errs++;
				end
			end
		end
	end

	// reset, drain and verdict
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (items.size() != 0 || start) @(posedge clk);
		while (owed != got) @(posedge clk);
		// a duplicate frame can still be walking with nothing owed
		repeat (400) @(posedge clk);
		if (owed_words.size() != 0)
			$error("%0d expected results never arrived", owed_words.size());
		if (errs == 0 && owed_words.size() == 0)
			$display("xor_parity_frame_recovery_tb: clean");
		else
			$display("xor_parity_frame_recovery_tb: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("xor_parity_frame_recovery_tb: errors");
		$finish;
	end

endmodule
